// File: rtl/b64e_pkg.sv
package b64e_pkg;

    localparam int unsigned ALPHA_REGS = 8;
    localparam int unsigned SLOTS      = 4;

    localparam logic [7:0] PAD_CHAR = 8'd61;

    typedef logic [5:0] t_group;

    // one accepted byte, expanded into up to four characters
    typedef struct packed {
        logic [SLOTS-1:0][5:0] idx;
        logic [SLOTS-1:0]      pad;
        logic [1:0]            last_idx;
        logic                  fin;
    } t_rec;

endpackage

// File: rtl/b64e_front.sv
module b64e_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_ok,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_final_byte,
    output logic          o_push,
    output b64e_pkg::t_rec o_rec
);

    logic [3:0] r_buf;
    logic [2:0] r_pend;
    logic [1:0] r_phase;

    logic [3:0] n_buf;
    logic [2:0] n_pend;
    logic [1:0] n_phase;

    logic [11:0] v;
    logic [2:0]  nc;
    logic [2:0]  np;
    logic [3:0]  rem;
    logic [1:0]  ph;
    logic [1:0]  pads;
    logic [2:0]  total;

    assign o_push = i_valid && i_push_ok;
    assign v      = {r_buf, i_data_byte};

    always_comb begin
        o_rec     = '0;
        nc        = 3'd1;
        np        = 3'd2;
        rem       = {2'b00, v[1:0]};
        case (r_pend)
            3'd4: begin
                o_rec.idx[0] = v[11:6];
                o_rec.idx[1] = v[5:0];
                nc  = 3'd2;
                np  = 3'd0;
                rem = 4'd0;
            end
            3'd2: begin
                o_rec.idx[0] = v[9:4];
                np  = 3'd4;
                rem = v[3:0];
            end
            default: begin
                o_rec.idx[0] = v[7:2];
            end
        endcase

        if (i_final_byte) begin
            if (np == 3'd4) begin
                o_rec.idx[nc[1:0]] = {rem, 2'b00};
                nc = nc + 3'd1;
            end else if (np == 3'd2) begin
                o_rec.idx[nc[1:0]] = {rem[1:0], 4'b0000};
                nc = nc + 3'd1;
            end
        end

        ph    = r_phase + nc[1:0];
        pads  = i_final_byte ? 2'(2'd0 - ph) : 2'd0;
        total = nc + {1'b0, pads};
        for (int s = 0; s < b64e_pkg::SLOTS; s++) begin
            o_rec.pad[s] = (3'(s) >= nc) && (3'(s) < total);
        end
        o_rec.last_idx = 2'(total - 3'd1);
        o_rec.fin      = i_final_byte;

        if (i_final_byte) begin
            n_buf   = 4'd0;
            n_pend  = 3'd0;
            n_phase = 2'd0;
        end else begin
            n_buf   = rem;
            n_pend  = np;
            n_phase = ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_pend  <= '0;
            r_phase <= '0;
        end else if (o_push) begin
            r_buf   <= n_buf;
            r_pend  <= n_pend;
            r_phase <= n_phase;
        end
    end

`ifndef ASSERT_OFF
    a_pend_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == 3'd0 || r_pend == 3'd2 || r_pend == 3'd4)
        else $error("pending bit count illegal");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && i_final_byte |=> r_pend == 3'd0 && r_phase == 2'd0 && r_buf == 4'd0)
        else $error("state not cleared after final byte");

    a_rec_ends_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && i_final_byte |-> 2'(r_phase + o_rec.last_idx + 2'd1) == 2'd0)
        else $error("message length not a multiple of four");
`endif

endmodule

// File: rtl/b64e_fifo.sv
module b64e_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64e_pkg::t_rec i_rec,
    output logic           o_push_ok,
    input  logic           i_pop,
    output logic           o_avail,
    output b64e_pkg::t_rec o_rec
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::t_rec r_mem [DEPTH];

    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_push_ok = (r_cnt != CNT_W'(DEPTH));
    assign o_avail   = (r_cnt != '0);
    assign o_rec     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_push_ok)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("queue underflow");
`endif

endmodule

// File: rtl/b64e_back.sv
module b64e_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [63:0]    i_cfg_data,
    input  logic           i_avail,
    input  b64e_pkg::t_rec i_rec,
    output logic           o_pop,
    input  logic           i_ready,
    output logic           o_valid,
    output logic [7:0]     o_out_char,
    output logic           o_is_padding,
    output logic           o_message_end
);

    logic [63:0] r_alpha [b64e_pkg::ALPHA_REGS];

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_pad;
    logic       r_end;
    logic [1:0] r_sel;

    logic       load;
    logic       last_slot;
    logic [5:0] grp;
    logic [7:0] lut_char;

    assign load      = i_avail && (!r_valid || i_ready);
    assign last_slot = (r_sel == i_rec.last_idx);
    assign o_pop     = load && last_slot;
    assign grp       = i_rec.idx[r_sel];
    assign lut_char  = r_alpha[grp[5:3]][{grp[2:0], 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < b64e_pkg::ALPHA_REGS; i++) begin
                r_alpha[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_alpha[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= last_slot ? 2'd0 : r_sel + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_rec.pad[r_sel] ? b64e_pkg::PAD_CHAR : lut_char;
            r_pad  <= i_rec.pad[r_sel];
            r_end  <= i_rec.fin && last_slot;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_char    = r_char;
    assign o_is_padding  = r_pad;
    assign o_message_end = r_end;

`ifndef ASSERT_OFF
    a_pad_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_padding |-> o_out_char == b64e_pkg::PAD_CHAR)
        else $error("pad transfer without pad character");

    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_avail |-> r_sel <= i_rec.last_idx)
        else $error("slot select past record end");
`endif

endmodule

// File: rtl/base64_byte_encoder_core.sv
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_data_byte, i_final_byte
// output    out        o_valid / i_ready   o_out_char, o_is_padding, o_message_end
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// A byte transfer is taken every cycle while the record queue has room.
// The output stage sends one character per cycle while i_ready is high; a byte
// gives one or two characters, a final byte up to four; 3 bytes give four.
// A byte's record enters the queue, then its first character is registered.
// Reset is synchronous, active low, and clears the alphabet to zero.
// Output stalls back up through the queue to o_ready.
module base64_byte_encoder_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_char,
    output logic        o_is_padding,
    output logic        o_message_end
);

    logic           push;
    logic           push_ok;
    logic           pop;
    logic           avail;
    b64e_pkg::t_rec front_rec;
    b64e_pkg::t_rec head_rec;

    assign o_ready = push_ok;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_ok    (push_ok),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_push       (push),
        .o_rec        (front_rec)
    );

    b64e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_rec     (front_rec),
        .o_push_ok (push_ok),
        .i_pop     (pop),
        .o_avail   (avail),
        .o_rec     (head_rec)
    );

    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_avail       (avail),
        .i_rec         (head_rec),
        .o_pop         (pop),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_out_char    (o_out_char),
        .o_is_padding  (o_is_padding),
        .o_message_end (o_message_end)
    );

endmodule

// File: test/tb.sv
module tb;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_msg_byte;

    typedef struct packed {
        logic [7:0] ch;
        logic       pad;
        logic       msg_end;
    } t_enc_char;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_data = '0;
    logic        in_final = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_char;
    logic        out_pad;
    logic        out_end;

    t_msg_byte   byte_q[$];
    t_enc_char   char_q[$];
    logic [63:0] alpha_next [b64e_pkg::ALPHA_REGS];
    logic [63:0] alpha_mirror [b64e_pkg::ALPHA_REGS];
    logic [13:0] enc_buf = '0;
    int          enc_pend = 0;
    logic [1:0]  enc_phase = '0;
    logic        steady = 1'b0;
    int          errors = 0;

    base64_byte_encoder_core dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_data_byte  (in_data),
        .i_final_byte (in_final),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_out_char   (out_char),
        .o_is_padding (out_pad),
        .o_message_end(out_end)
    );

    always #6 clk = ~clk;

    initial begin
        for (int r = 0; r < b64e_pkg::ALPHA_REGS; r++) begin
            alpha_mirror[r] = '0;
            alpha_next[r]   = '0;
        end
    end

    function automatic logic [7:0] alpha_char(input logic [5:0] grp);
        return alpha_mirror[grp[5:3]][grp[2:0] * 8 +: 8];
    endfunction

    // expected characters for one transfer, oldest bits first
    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        int         nb;
        logic [5:0] grp;
        t_enc_char  tail;
        enc_buf = {enc_buf[5:0], b};
        nb = enc_pend + 8;
        while (nb >= 6) begin
            grp = 6'(enc_buf >> (nb - 6));
            char_q.push_back('{alpha_char(grp), 1'b0, 1'b0});
            nb = nb - 6;
            enc_phase = enc_phase + 2'd1;
        end
        enc_buf = enc_buf & ((14'd1 << nb) - 14'd1);
        if (fin) begin
            if (nb > 0) begin
                grp = 6'(enc_buf << (6 - nb));
                char_q.push_back('{alpha_char(grp), 1'b0, 1'b0});
                enc_phase = enc_phase + 2'd1;
            end
            while (enc_phase != 2'd0) begin
                char_q.push_back('{b64e_pkg::PAD_CHAR, 1'b1, 1'b0});
                enc_phase = enc_phase + 2'd1;
            end
            tail = char_q.pop_back();
            tail.msg_end = 1'b1;
            char_q.push_back(tail);
            enc_buf = '0;
            nb = 0;
        end
        enc_pend = nb;
    endfunction

    always @(posedge clk) begin
        if (rst_n && cfg_we) begin
            alpha_mirror[cfg_idx] <= cfg_data;
        end
    end

    // driver
    always @(posedge clk) begin : drv
        t_msg_byte nxt;
        if (in_valid && in_ready) begin
            encode_byte(in_data, in_final);
        end
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (byte_q.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
                nxt = byte_q.pop_front();
                in_valid <= 1'b1;
                in_data  <= nxt.data;
                in_final <= nxt.fin;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    // monitor
    always @(posedge clk) begin : mon
        t_enc_char want;
        if (rst_n && out_valid && out_ready) begin
            if (char_q.size() == 0) begin
                $error("unexpected transfer: out_char %0d", out_char);
                errors++;
            end else begin
                want = char_q.pop_front();
                if (out_char !== want.ch) begin
                    $error("out_char: expected %0d, got %0d", want.ch, out_char);
                    errors++;
                end
                if (out_pad !== want.pad) begin
                    $error("is_padding: expected %0d, got %0d", want.pad, out_pad);
                    errors++;
                end
                if (out_end !== want.msg_end) begin
                    $error("message_end: expected %0d, got %0d", want.msg_end, out_end);
                    errors++;
                end
            end
        end
    end

    task automatic add_byte(input logic [7:0] d, input logic f);
        byte_q.push_back('{d, f});
    endtask

    task automatic queue_messages(input int target);
        int cnt = 0;
        int len;
        while (cnt < target) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
            for (int k = 0; k < len; k++) begin
                add_byte(8'($urandom), k == len - 1);
            end
            cnt += len;
        end
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (byte_q.size() != 0 || in_valid || char_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic program_alphabet();
        for (int r = 0; r < b64e_pkg::ALPHA_REGS; r++) begin
            @(posedge clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= 3'(r);
            cfg_data <= alpha_next[r];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        logic [7:0] c;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // alphabet still at reset value
        add_byte(8'h4d, 1'b1);
        add_byte(8'hff, 1'b0);
        add_byte(8'hff, 1'b1);
        wait_idle();

        for (int k = 0; k < 64; k++) begin
            if (k < 26)       c = 8'(65 + k);
            else if (k < 52)  c = 8'(97 + k - 26);
            else if (k < 62)  c = 8'(48 + k - 52);
            else if (k == 62) c = 8'd43;
            else              c = 8'd47;
            alpha_next[k >> 3][(k & 7) * 8 +: 8] = c;
        end
        program_alphabet();

        // one, two and three byte tails, extremes, top alphabet entries
        add_byte(8'h4d, 1'b1);
        add_byte(8'h4d, 1'b0);
        add_byte(8'h61, 1'b1);
        add_byte(8'h4d, 1'b0);
        add_byte(8'h61, 1'b0);
        add_byte(8'h6e, 1'b1);
        add_byte(8'h00, 1'b1);
        add_byte(8'hff, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'hff, 1'b1);
        add_byte(8'hff, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'hfb, 1'b0);
        add_byte(8'hef, 1'b0);
        add_byte(8'hbe, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'h10, 1'b0);
        add_byte(8'h83, 1'b0);
        add_byte(8'h10, 1'b1);
        wait_idle();

        for (int r = 0; r < b64e_pkg::ALPHA_REGS; r++) alpha_next[r] = '1;
        program_alphabet();
        queue_messages(55);
        wait_idle();

        // alphabet made of '=' bytes; pads told apart only by is_padding
        for (int r = 0; r < b64e_pkg::ALPHA_REGS; r++) begin
            alpha_next[r] = {8{b64e_pkg::PAD_CHAR}};
        end
        program_alphabet();
        queue_messages(35);
        wait_idle();
        queue_messages(35);
        wait_idle();

        for (int r = 0; r < b64e_pkg::ALPHA_REGS; r++) alpha_next[r] = {$urandom, $urandom};
        program_alphabet();
        steady = 1'b1;
        queue_messages(70);
        wait_idle();
        steady = 1'b0;

        for (int r = 0; r < b64e_pkg::ALPHA_REGS; r++) alpha_next[r] = {$urandom, $urandom};
        program_alphabet();
        queue_messages(70);
        wait_idle();

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
